### hdl/assert_macros.svh
//------------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL.
//------------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Invariant checked at every edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("invariant check failed");

`endif

### hdl/ivm_pkg.sv
//------------------------------------------------------------------------------
// ivm_pkg
// Shared types and constants of the interval value map.
//------------------------------------------------------------------------------
package ivm_pkg;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic [7:0] INIT_VALUE_RESET = 8'd65;

  localparam int IN_DATA_BITS  = 72;
  localparam int OUT_DATA_BITS = 24;

  // controller to datapath
  typedef struct packed {
    logic start;  // load transaction, reset scan
    logic rd;     // read entry at scan index
    logic ev;     // evaluate read entry
    logic tail;   // evaluate past the last entry
    logic fin;    // load result, commit table
  } ivm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic consumed;
    logic last;
    logic stop;
    logic tail_done;
    logic is_empty;
    logic is_lookup;
  } ivm_sts_t;

endpackage

### hdl/ivm_datapath.sv
//------------------------------------------------------------------------------
// ivm_datapath
// Double-banked boundary table, scan/merge logic and result register.
//------------------------------------------------------------------------------
module ivm_datapath import ivm_pkg::*; #(
  parameter int MAX_ENTRIES = 64,
  parameter int KEY_BITS    = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  ivm_cmd_t                cmd,
  output ivm_sts_t                sts,
  input  logic                    in_user,
  input  logic [IN_DATA_BITS-1:0] in_data,
  input  logic                    cfg_we,
  input  logic [7:0]              cfg_data,
  output logic [7:0]              res_value,
  output logic [1:0]              res_status,
  output logic [6:0]              res_count
);

  localparam int IW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 3);
  localparam logic [CW-1:0] MAX_N = CW'(MAX_ENTRIES);

  typedef enum logic [1:0] {PH_BELOW, PH_INSIDE, PH_ABOVE} phase_t;

  logic [KEY_BITS-1:0] key_m0 [MAX_ENTRIES];
  logic [KEY_BITS-1:0] key_m1 [MAX_ENTRIES];
  logic [7:0]          val_m0 [MAX_ENTRIES];
  logic [7:0]          val_m1 [MAX_ENTRIES];

  logic                sel;
  logic [CW-1:0]       cnt;
  logic [7:0]          v0;
  logic [7:0]          v0_new;
  logic [IW-1:0]       idx;
  logic [CW-1:0]       n;
  phase_t              phase;
  logic [7:0]          prev;
  logic [7:0]          endv;
  logic [7:0]          lv;
  logic                it_act;
  logic [KEY_BITS-1:0] it_b;
  logic [KEY_BITS-1:0] it_e;
  logic [7:0]          it_val;
  logic [KEY_BITS-1:0] rd_key;
  logic [7:0]          rd_val;
  logic                rd_zero;

  logic [KEY_BITS-1:0] rk;
  logic [7:0]          rv;
  logic                emit;
  logic [KEY_BITS-1:0] ek;
  logic [7:0]          ev;
  phase_t              phase_next;
  logic [7:0]          prev_next;
  logic [7:0]          endv_next;
  logic [7:0]          lv_next;
  logic                empty;

  assign rk    = rd_zero ? '0 : rd_key;
  assign rv    = rd_zero ? v0 : rd_val;
  assign empty = !(it_b < it_e);

  always_comb begin
    emit          = 1'b0;
    ek            = rk;
    ev            = rv;
    phase_next    = phase;
    prev_next     = prev;
    endv_next     = endv;
    lv_next       = lv;
    sts           = '0;
    sts.is_empty  = empty;
    sts.is_lookup = it_act;
    if (it_act) begin
      if (cmd.tail) begin
        sts.tail_done = 1'b1;
      end else if (rk <= it_b) begin
        lv_next      = rv;
        sts.consumed = 1'b1;
      end else begin
        sts.stop = 1'b1;
      end
    end else begin
      unique case (phase)
        PH_BELOW: begin
          if (!cmd.tail && rk < it_b) begin
            emit         = 1'b1;
            prev_next    = rv;
            endv_next    = rv;
            sts.consumed = 1'b1;
          end else begin
            phase_next = PH_INSIDE;
            if (n == '0 || prev != it_val) begin
              emit = 1'b1;
              ek   = it_b;
              ev   = it_val;
            end
          end
        end
        PH_INSIDE: begin
          if (!cmd.tail && rk < it_e) begin
            endv_next    = rv;
            sts.consumed = 1'b1;
          end else if (!cmd.tail && rk == it_e) begin
            sts.consumed = 1'b1;
            phase_next   = PH_ABOVE;
            if (rv != it_val) begin
              emit = 1'b1;
              ek   = it_e;
            end
          end else begin
            phase_next = PH_ABOVE;
            if (endv != it_val) begin
              emit = 1'b1;
              ek   = it_e;
              ev   = endv;
            end
          end
        end
        PH_ABOVE: begin
          if (cmd.tail) begin
            sts.tail_done = 1'b1;
          end else begin
            emit         = 1'b1;
            sts.consumed = 1'b1;
          end
        end
        default: begin
          phase_next = PH_ABOVE;
        end
      endcase
    end
    sts.last = sts.consumed && (CW'(idx) + CW'(1) == cnt);
  end

  // bank read, registered
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_key  <= sel ? key_m1[idx] : key_m0[idx];
      rd_val  <= sel ? val_m1[idx] : val_m0[idx];
      rd_zero <= (idx == '0);
    end
  end

  // merge write into the idle bank
  always_ff @(posedge clk) begin
    if ((cmd.ev || cmd.tail) && emit && n != '0 && n < MAX_N) begin
      if (sel) begin
        key_m0[n[IW-1:0]] <= ek;
        val_m0[n[IW-1:0]] <= ev;
      end else begin
        key_m1[n[IW-1:0]] <= ek;
        val_m1[n[IW-1:0]] <= ev;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      it_act <= in_user;
      it_b   <= KEY_BITS'(in_data[31:0]);
      it_e   <= KEY_BITS'(in_data[63:32]);
      it_val <= in_data[71:64];
      idx    <= '0;
      n      <= '0;
      phase  <= PH_BELOW;
      prev   <= '0;
      endv   <= '0;
      lv     <= '0;
    end else if (cmd.ev || cmd.tail) begin
      phase <= phase_next;
      prev  <= prev_next;
      endv  <= endv_next;
      lv    <= lv_next;
      if (emit) begin
        n <= n + CW'(1);
        if (n == '0) begin
          v0_new <= ev;
        end
      end
      if (sts.consumed) begin
        idx <= idx + IW'(1);
      end
    end
    if (cmd.fin) begin
      res_value  <= it_act ? lv : 8'd0;
      res_count  <= 7'(cnt);
      res_status <= ST_DONE;
      if (!it_act) begin
        if (empty) begin
          res_status <= ST_EMPTY;
        end else if (n > MAX_N) begin
          res_status <= ST_FULL;
        end else begin
          res_count <= 7'(n);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sel <= 1'b0;
      cnt <= CW'(1);
      v0  <= INIT_VALUE_RESET;
    end else if (cfg_we) begin
      cnt <= CW'(1);
      v0  <= cfg_data;
    end else if (cmd.fin && !it_act && !empty && n <= MAX_N) begin
      sel <= ~sel;
      cnt <= n;
      v0  <= v0_new;
    end
  end

endmodule

### hdl/ivm_ctrl.sv
//------------------------------------------------------------------------------
// ivm_ctrl
// Sequencer for table scans and result handoff.
//------------------------------------------------------------------------------
module ivm_ctrl import ivm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output ivm_cmd_t cmd,
  input  ivm_sts_t sts
);

  typedef enum logic [2:0] {S_IDLE, S_CHK, S_RD, S_EV, S_TAIL, S_FIN} state_t;

  state_t state;
  state_t state_next;
  logic   load;

  assign in_ready = (state == S_IDLE);
  assign load     = (state == S_FIN) && (!out_valid || out_ready);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        state_next = (sts.is_lookup || !sts.is_empty) ? S_RD : S_FIN;
      end
      S_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_EV;
      end
      S_EV: begin
        cmd.ev = 1'b1;
        priority if (sts.stop) begin
          state_next = S_FIN;
        end else if (sts.last) begin
          state_next = S_TAIL;
        end else if (sts.consumed) begin
          state_next = S_RD;
        end else begin
          state_next = S_EV;
        end
      end
      S_TAIL: begin
        cmd.tail = 1'b1;
        if (sts.tail_done) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (load) begin
          cmd.fin    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### hdl/interval_value_map_top.sv
//------------------------------------------------------------------------------
// interval_value_map_top
// Canonical interval table with range assign and key lookup.
//
//  channel  dir  handshake                      payload
//  s_*      in   s_tvalid/s_tready              action, key, range_end, value
//  m_*      out  m_tvalid/m_tready              lookup_value, status, entries_used
//  apb      in   psel/penable/pwrite, pready=1  initial_value at 0x0
//
// Each stored boundary takes one read and one merge step on the single bank
// read port. Lookups stop at the first boundary above the key; empty ranges
// skip the scan and go straight to the result.
// Reset and an initial_value write leave one boundary at key 0.
// A result waits in the output register while m_tready is low.
//------------------------------------------------------------------------------
module interval_value_map_top import ivm_pkg::*; #(
  parameter int MAX_ENTRIES = 64,
  parameter int KEY_BITS    = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [IN_DATA_BITS-1:0]  s_tdata,   // key[31:0], range_end, value
  input  logic                     s_tuser,   // action
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [OUT_DATA_BITS-1:0] m_tdata,   // lookup_value, status, entries_used
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [2:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  `include "assert_macros.svh"

  ivm_cmd_t   cmd;
  ivm_sts_t   sts;
  logic       cfg_we;
  logic [7:0] init_value;
  logic [7:0] res_value;
  logic [1:0] res_status;
  logic [6:0] res_count;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {24'd0, init_value} : 32'd0;
  assign m_tdata = {7'd0, res_count, res_status, res_value};

  always_ff @(posedge clk) begin
    if (rst) begin
      init_value <= INIT_VALUE_RESET;
    end else if (cfg_we) begin
      init_value <= pwdata[7:0];
    end
  end

  ivm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  ivm_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .KEY_BITS    (KEY_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_user    (s_tuser),
    .in_data    (s_tdata),
    .cfg_we     (cfg_we),
    .cfg_data   (pwdata[7:0]),
    .res_value  (res_value),
    .res_status (res_status),
    .res_count  (res_count)
  );

  `ASSERT_IMPLY(a_count_nz, clk, rst, m_tvalid, res_count != 7'd0)
  `ASSERT_IMPLY(a_status_code, clk, rst, m_tvalid, res_status != 2'd3)
  `ASSERT_IMPLY(a_reject_zero, clk, rst, m_tvalid && res_status != ST_DONE, res_value == 8'd0)
  `ASSERT_ALWAYS(a_one_cmd, clk, rst, $onehot0({cmd.start, cmd.rd, cmd.ev, cmd.tail, cmd.fin}))

endmodule

### bench/testbench.sv
//------------------------------------------------------------------------------
// testbench
// Checks interval_value_map_top: a directed table of assigns and lookups,
// then random range assigns (some of them empty) and lookups, each result compared
// with a boundary-table predictor. Initial value is rewritten between phases.
//------------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ivm_pkg::*;

  localparam int MAXN = 64;
  localparam logic [2:0] REG_INIT_VALUE = 3'd0;
  localparam logic ACT_ASSIGN = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;
  localparam longint LIMIT = 4000000;

  typedef struct packed {
    logic [7:0] lookup_value;
    logic [1:0] status;
    logic [6:0] entries_used;
  } map_result_t;

  typedef struct {
    logic        act;
    logic [31:0] key;
    logic [31:0] rend;
    logic [7:0]  value;
    logic        has_exp;
    map_result_t exp_res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_BITS-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_tdata;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  interval_value_map_top dut (.*);

  always #5 clk = ~clk;

  // boundary table mirror
  logic [31:0] bkeys[MAXN];
  logic [7:0]  bvals[MAXN];
  int          bcount;

  map_result_t pending_results[$];
  int  errors = 0;
  int  send_idle = 0, recv_idle = 0;
  longint cycles = 0;

  function automatic logic [7:0] value_at_key(logic [31:0] k);
    logic [7:0] v;
    v = bvals[0];
    for (int i = 0; i < bcount; i++) begin
      if (bkeys[i] <= k) v = bvals[i];
      else break;
    end
    return v;
  endfunction

  function automatic logic [1:0] assign_range(logic [31:0] b, logic [31:0] e,
                                              logic [7:0] v);
    logic [31:0] tk[MAXN+2];
    logic [7:0]  tv[MAXN+2];
    logic [7:0]  ev;
    int n, i;
    n = 0;
    i = 0;
    ev = value_at_key(e);
    while (i < bcount && bkeys[i] < b) begin
      tk[n] = bkeys[i]; tv[n] = bvals[i]; n++; i++;
    end
    if (n == 0 || tv[n-1] != v) begin
      tk[n] = b; tv[n] = v; n++;
    end
    while (i < bcount && bkeys[i] < e) i++;
    if (i < bcount && bkeys[i] == e) begin
      if (bvals[i] != v) begin
        tk[n] = e; tv[n] = bvals[i]; n++;
      end
      i++;
    end else if (ev != v) begin
      tk[n] = e; tv[n] = ev; n++;
    end
    while (i < bcount) begin
      if (n >= MAXN + 2) return ST_FULL;
      tk[n] = bkeys[i]; tv[n] = bvals[i]; n++; i++;
    end
    if (n > MAXN) return ST_FULL;
    for (int j = 0; j < n; j++) begin
      bkeys[j] = tk[j]; bvals[j] = tv[j];
    end
    bcount = n;
    return ST_DONE;
  endfunction

  function automatic map_result_t predict_result(logic act, logic [31:0] k,
                                                 logic [31:0] e, logic [7:0] v);
    map_result_t r;
    r = '0;
    if (act == ACT_LOOKUP) r.lookup_value = value_at_key(k);
    else if (!(k < e)) r.status = ST_EMPTY;
    else r.status = assign_range(k, e, v);
    r.entries_used = 7'(bcount);
    return r;
  endfunction

  function automatic void clear_table(logic [7:0] v);
    bkeys[0] = '0;
    bvals[0] = v;
    bcount = 1;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("%0t timeout", $time);
      $display("** interval_value_map_top: FAILED **");
      $finish;
    end
  end

  // result checker and receiver stall
  always @(posedge clk) begin
    map_result_t got, want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.lookup_value = m_tdata[7:0];
        got.status       = m_tdata[9:8];
        got.entries_used = m_tdata[16:10];
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t unexpected result %h", $time, got);
        end else begin
          want = pending_results.pop_front();
          if (got.lookup_value !== want.lookup_value) begin
            errors++;
            $display("%0t lookup_value exp %0d got %0d", $time,
                     want.lookup_value, got.lookup_value);
          end
          if (got.status !== want.status) begin
            errors++;
            $display("%0t status exp %0d got %0d", $time, want.status, got.status);
          end
          if (got.entries_used !== want.entries_used) begin
            errors++;
            $display("%0t entries_used exp %0d got %0d", $time,
                     want.entries_used, got.entries_used);
          end
        end
      end
      m_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic apb_write(logic [2:0] a, logic [31:0] d);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= a; pwdata <= d; penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic drain;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic set_initial(logic [7:0] v);
    drain();
    apb_write(REG_INIT_VALUE, {24'd0, v});
    clear_table(v);
  endtask

  // one transaction; s_tvalid stays high if the next one follows at once
  task automatic send_item(logic act, logic [31:0] k, logic [31:0] e, logic [7:0] v,
                           logic has_exp, map_result_t exp_res);
    map_result_t r;
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= act;
    s_tdata <= {v, e, k};
    do @(posedge clk); while (!s_tready);
    r = predict_result(act, k, e, v);
    if (has_exp && r !== exp_res) begin
      errors++;
      $display("%0t table row exp %h predictor %h", $time, exp_res, r);
    end
    pending_results.push_back(r);
  endtask

  task automatic idle_input;
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_item;
    logic [31:0] k, e;
    logic [7:0] v;
    int sel;
    sel = $urandom_range(99);
    v = (sel % 3 == 0) ? 8'($urandom_range(3)) : 8'($urandom);
    if (sel < 60) begin
      // short ranges in a small key window so boundaries pile up
      k = $urandom_range(1000);
      e = k + $urandom_range(1, 60);
      send_item(ACT_ASSIGN, k, e, v, 1'b0, '0);
    end else if (sel < 68) begin
      k = $urandom; e = $urandom;
      send_item(ACT_ASSIGN, k, e, v, 1'b0, '0);
    end else if (sel < 72) begin
      k = $urandom_range(1000);
      send_item(ACT_ASSIGN, k, k - $urandom_range(1), v, 1'b0, '0);
    end else if (sel < 92) begin
      send_item(ACT_LOOKUP, $urandom_range(1100), $urandom, 8'($urandom), 1'b0, '0);
    end else begin
      send_item(ACT_LOOKUP, $urandom, $urandom, 8'($urandom), 1'b0, '0);
    end
  endtask

  dir_row_t rows[] = '{
    '{ACT_LOOKUP, 32'h0, 32'h0, 8'h0, 1'b1, '{8'd65, ST_DONE, 7'd1}},
    '{ACT_LOOKUP, 32'hFFFFFFFF, 32'hFFFFFFFF, 8'hFF, 1'b1, '{8'd65, ST_DONE, 7'd1}},
    '{ACT_ASSIGN, 32'd10, 32'd10, 8'd7, 1'b1, '{8'd0, ST_EMPTY, 7'd1}},
    '{ACT_ASSIGN, 32'hFFFFFFFF, 32'h0, 8'd7, 1'b1, '{8'd0, ST_EMPTY, 7'd1}},
    '{ACT_ASSIGN, 32'd5, 32'd9, 8'd65, 1'b1, '{8'd0, ST_DONE, 7'd1}},
    '{ACT_ASSIGN, 32'd10, 32'd20, 8'd7, 1'b1, '{8'd0, ST_DONE, 7'd3}},
    '{ACT_LOOKUP, 32'd9, 32'd0, 8'd0, 1'b1, '{8'd65, ST_DONE, 7'd3}},
    '{ACT_LOOKUP, 32'd10, 32'd0, 8'd0, 1'b1, '{8'd7, ST_DONE, 7'd3}},
    '{ACT_LOOKUP, 32'd19, 32'd0, 8'd0, 1'b1, '{8'd7, ST_DONE, 7'd3}},
    '{ACT_LOOKUP, 32'd20, 32'd0, 8'd0, 1'b1, '{8'd65, ST_DONE, 7'd3}},
    '{ACT_ASSIGN, 32'd20, 32'd30, 8'd7, 1'b0, '0},
    '{ACT_ASSIGN, 32'd0, 32'd5, 8'hFF, 1'b0, '0},
    '{ACT_ASSIGN, 32'd12, 32'd15, 8'd7, 1'b0, '0},
    '{ACT_ASSIGN, 32'hFFFFFFF0, 32'hFFFFFFFF, 8'h00, 1'b0, '0},
    '{ACT_LOOKUP, 32'hFFFFFFFE, 32'd0, 8'd0, 1'b0, '0},
    '{ACT_LOOKUP, 32'hFFFFFFFF, 32'd0, 8'd0, 1'b0, '0},
    '{ACT_ASSIGN, 32'd0, 32'hFFFFFFFF, 8'd65, 1'b0, '0},
    '{ACT_LOOKUP, 32'hAAAAAAAA, 32'h55555555, 8'hAA, 1'b0, '0},
    '{ACT_LOOKUP, 32'h55555555, 32'hAAAAAAAA, 8'h55, 1'b0, '0},
    '{ACT_ASSIGN, 32'd1, 32'd2, 8'd1, 1'b0, '0}
  };

  initial begin
    clear_table(INIT_VALUE_RESET);
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle = 9; recv_idle = 81;
    foreach (rows[i])
      send_item(rows[i].act, rows[i].key, rows[i].rend, rows[i].value,
                rows[i].has_exp, rows[i].exp_res);
    idle_input();

    // fill toward a full table: alternating values on disjoint unit ranges
    set_initial(8'h00);
    for (int i = 0; i < 40; i++)
      send_item(ACT_ASSIGN, 32'(4 * i + 1), 32'(4 * i + 2), 8'(1 + i % 2), 1'b0, '0);
    for (int i = 0; i < 163; i++) random_item();
    idle_input();

    // hold off until all results are back
    drain();

    set_initial(8'hFF);
    send_idle = 81; recv_idle = 9;
    for (int i = 0; i < 163; i++) random_item();
    idle_input();

    set_initial(8'($urandom));
    send_idle = 0; recv_idle = 0;
    for (int i = 0; i < 163; i++) random_item();
    idle_input();

    drain();
    if (errors == 0) begin
      $display("** interval_value_map_top: PASSED **");
    end else begin
      $display("** interval_value_map_top: FAILED **");
    end
    $finish;
  end
endmodule

### files.f
+incdir+hdl
hdl/ivm_pkg.sv
hdl/ivm_datapath.sv
hdl/ivm_ctrl.sv
hdl/interval_value_map_top.sv
bench/testbench.sv
